// File: design/isoq_pkg.sv
// shared types and constants for the interval set overlap query unit
// no dependencies; imported by the interfaces and every module of the block
package isoq_pkg;

  localparam int CAPACITY = 32;
  localparam int COORD_W  = 32;
  localparam int IDX_W    = $clog2(CAPACITY);

  // request type codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_ERASE  = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISS    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic signed [COORD_W-1:0] lo;
    logic signed [COORD_W-1:0] hi;
  } isoq_pair_t;

  // strobes from the controller to every cell
  typedef struct packed {
    logic capture;
    logic do_insert;
    logic do_erase;
  } isoq_ctl_t;

endpackage

// File: design/isoq_if.sv
// request and response channel interfaces (valid/ready)
// depends on isoq_pkg
interface isoq_req_if import isoq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                req_type;
  logic signed [COORD_W-1:0] lo;
  logic signed [COORD_W-1:0] hi;

  modport source (output valid, req_type, lo, hi, input ready);
  modport sink   (input valid, req_type, lo, hi, output ready);
endinterface

interface isoq_rsp_if import isoq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic signed [COORD_W-1:0] hit_lo;
  logic signed [COORD_W-1:0] hit_hi;

  modport source (output valid, status, hit_lo, hit_hi, input ready);
  modport sink   (input valid, status, hit_lo, hit_hi, output ready);
endinterface

// File: design/isoq_cell.sv
// one slot of the sorted interval chain: holds an entry, compares it with
// the request and shifts with its neighbors; depends on isoq_pkg
module isoq_cell import isoq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  isoq_ctl_t  ctl,
  input  isoq_pair_t cmp,
  input  isoq_pair_t new_ent,
  input  isoq_pair_t prev_ent,
  input  logic       prev_valid,
  input  logic       prev_gt,
  input  isoq_pair_t next_ent,
  input  logic       next_valid,
  output isoq_pair_t ent,
  output logic       valid,
  output logic       gt,
  output logic       eq,
  output logic       hit
);

  logic gt_next, eq_next, hit_next;

  always_comb begin
    gt_next  = valid && ((ent.lo > cmp.lo) || ((ent.lo == cmp.lo) && (ent.hi > cmp.hi)));
    eq_next  = valid && (ent.lo == cmp.lo) && (ent.hi == cmp.hi);
    hit_next = valid && (ent.lo < cmp.hi) && (cmp.lo < ent.hi);
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      gt  <= gt_next;
      eq  <= eq_next;
      hit <= hit_next;
    end
  end

  // entry payload, no reset
  always_ff @(posedge clk) begin
    if (ctl.do_insert) begin
      if (prev_gt) begin
        ent <= prev_ent;
      end else if (prev_valid && (!valid || gt)) begin
        ent <= new_ent;
      end
    end else if (ctl.do_erase && (gt || eq)) begin
      ent <= next_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.do_insert) begin
      if (prev_gt || (prev_valid && (!valid || gt))) begin
        valid <= 1'b1;
      end
    end else if (ctl.do_erase && (gt || eq)) begin
      valid <= next_valid;
    end
  end

endmodule

// File: design/interval_set_overlap_query_unit.sv
// interval set overlap query unit: one request at a time, one result each;
// on accept the compare flags of all cells are registered; when the output
// register is free or being drained, the chain shifts and the output register loads
// no new request is taken until the last one has finished, and a finish waits while a result is held
// reset clears the occupancy of every cell at once; no clearing pass
module interval_set_overlap_query_unit import isoq_pkg::*; (
  input logic      clk,
  input logic      rst,
  isoq_req_if.sink req,
  isoq_rsp_if.source rsp
);

  // request kinds held while a request is in flight
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_ERASE  = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;
  localparam logic [1:0] KIND_BAD    = 2'd3;

  logic       busy;
  logic [1:0] kind;
  isoq_pair_t req_ent;

  isoq_ctl_t  ctl;
  isoq_pair_t cmp;
  logic       accept;
  logic       done;

  // chain signals
  isoq_pair_t         ent_a      [CAPACITY];
  isoq_pair_t         prev_ent_a [CAPACITY];
  isoq_pair_t         next_ent_a [CAPACITY];
  logic [CAPACITY-1:0] valid_v, gt_v, eq_v, hit_v;
  logic [CAPACITY-1:0] prev_valid_v, prev_gt_v, next_valid_v;

  logic                any_eq, any_hit, full;
  logic [CAPACITY-1:0] first_hit;
  isoq_pair_t          hit_ent;

  logic [1:0]          status_next;
  logic                ins_ok, era_ok;

  // accept only between requests; the cells compare the payload on the way in
  assign req.ready = !busy;
  assign accept    = req.valid && req.ready;
  // finish when the output register is free or being drained
  assign done      = busy && (!rsp.valid || rsp.ready);

  assign cmp = '{lo: req.lo, hi: req.hi};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_ent <= cmp;
      if (req.req_type == REQ_UNUSED || req.lo >= req.hi) begin
        kind <= KIND_BAD;
      end else begin
        case (req.req_type)
          REQ_INSERT: kind <= KIND_INSERT;
          REQ_ERASE:  kind <= KIND_ERASE;
          REQ_QUERY:  kind <= KIND_QUERY;
          default:    kind <= KIND_BAD;
        endcase
      end
    end
  end

  // neighbor wiring: the head sees a smaller, occupied slot before it,
  // the tail sees an empty slot after it
  for (genvar i = 0; i < CAPACITY; i++) begin : g_link
    if (i == 0) begin : g_head
      assign prev_ent_a[i]   = ent_a[i];
      assign prev_valid_v[i] = 1'b1;
      assign prev_gt_v[i]    = 1'b0;
    end else begin : g_body
      assign prev_ent_a[i]   = ent_a[i-1];
      assign prev_valid_v[i] = valid_v[i-1];
      assign prev_gt_v[i]    = gt_v[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next_ent_a[i]   = ent_a[i];
      assign next_valid_v[i] = 1'b0;
    end else begin : g_mid
      assign next_ent_a[i]   = ent_a[i+1];
      assign next_valid_v[i] = valid_v[i+1];
    end

    isoq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .cmp        (cmp),
      .new_ent    (req_ent),
      .prev_ent   (prev_ent_a[i]),
      .prev_valid (prev_valid_v[i]),
      .prev_gt    (prev_gt_v[i]),
      .next_ent   (next_ent_a[i]),
      .next_valid (next_valid_v[i]),
      .ent        (ent_a[i]),
      .valid      (valid_v[i]),
      .gt         (gt_v[i]),
      .eq         (eq_v[i]),
      .hit        (hit_v[i])
    );
  end

  // occupied cells are a prefix kept in (lo, hi) order, so the first
  // overlapping cell is the smallest overlapping interval
  assign any_eq    = |eq_v;
  assign any_hit   = |hit_v;
  assign full      = valid_v[CAPACITY-1];
  assign first_hit = hit_v & (~hit_v + CAPACITY'(1));

  always_comb begin
    hit_ent = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_ent = hit_ent | (ent_a[i] & {(2*COORD_W){first_hit[i]}});
    end
  end

  // result and chain update
  always_comb begin
    ins_ok = 1'b0;
    era_ok = 1'b0;
    case (kind)
      KIND_INSERT: begin
        if (any_eq) begin
          status_next = ST_MISS;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          status_next = ST_OK;
          ins_ok      = 1'b1;
        end
      end
      KIND_ERASE: begin
        status_next = any_eq ? ST_OK : ST_MISS;
        era_ok      = any_eq;
      end
      KIND_QUERY: status_next = any_hit ? ST_OK : ST_MISS;
      default:    status_next = ST_INVALID;
    endcase
  end

  assign ctl.capture   = accept;
  assign ctl.do_insert = done && ins_ok;
  assign ctl.do_erase  = done && era_ok;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (done) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      rsp.status <= status_next;
      if (kind == KIND_QUERY && any_hit) begin
        rsp.hit_lo <= hit_ent.lo;
        rsp.hit_hi <= hit_ent.hi;
      end else begin
        rsp.hit_lo <= '0;
        rsp.hit_hi <= '0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // occupied cells always form a prefix of the chain
  a_prefix: assert property (@(posedge clk) disable iff (rst)
    (valid_v & (valid_v + CAPACITY'(1))) == '0)
    else $error("occupied cells not contiguous");

  // insert and erase never shift the chain in the same cycle
  a_one_shift: assert property (@(posedge clk) disable iff (rst)
    !(ctl.do_insert && ctl.do_erase))
    else $error("insert and erase together");

  // a finished request always shows up in the output register
  a_done_out: assert property (@(posedge clk) disable iff (rst)
    done |=> rsp.valid)
    else $error("result lost");

  // at most one cell matches a request exactly: the set holds no duplicates
  a_unique: assert property (@(posedge clk) disable iff (rst)
    busy |-> $onehot0(eq_v))
    else $error("duplicate entry in set");
`endif

endmodule

// File: verif/tb_interval_set_overlap_query_unit.sv
// self-checking testbench for interval_set_overlap_query_unit: directed and random
// insert, erase and overlap query requests with a cycle-free interval set predictor
// depends on isoq_pkg, isoq_req_if, isoq_rsp_if and the unit itself
module tb_interval_set_overlap_query_unit import isoq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] C_MAX = ~C_MIN;
  localparam int RANDOM_ITEMS  = 900;
  localparam int SETTLE_CYCLES = 20;

  typedef struct {
    logic [1:0]                op;
    logic signed [COORD_W-1:0] lo;
    logic signed [COORD_W-1:0] hi;
  } request_t;

  typedef struct {
    logic [1:0]                status;
    logic signed [COORD_W-1:0] hit_lo;
    logic signed [COORD_W-1:0] hit_hi;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  isoq_req_if req_ch ();
  isoq_rsp_if rsp_ch ();

  interval_set_overlap_query_unit uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #5 clk = ~clk;

  // requests waiting to be sent, and answers predicted for accepted requests
  request_t request_backlog[$];
  answer_t  awaited_answers[$];
  int unsigned error_count = 0;

  // shadow copy of the stored interval set
  logic signed [COORD_W-1:0] set_lo [CAPACITY];
  logic signed [COORD_W-1:0] set_hi [CAPACITY];
  bit                        set_used [CAPACITY];

  // applies one request to the shadow set and returns the answer it must produce
  function automatic answer_t interval_set_apply(request_t r);
    answer_t a;
    int free_slot;
    bit found;
    a.status = ST_MISS;
    a.hit_lo = '0;
    a.hit_hi = '0;
    free_slot = -1;
    found = 1'b0;
    // empty or reversed range, and the unused opcode, leave the set alone
    if (r.op == REQ_UNUSED || r.lo >= r.hi) begin
      a.status = ST_INVALID;
      return a;
    end
    case (r.op)
      REQ_INSERT: begin
        // duplicate check wins over the full check
        for (int i = 0; i < CAPACITY; i++) begin
          if (set_used[i]) begin
            if (set_lo[i] == r.lo && set_hi[i] == r.hi) return a;
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
        if (free_slot < 0) begin
          a.status = ST_FULL;
        end else begin
          set_lo[free_slot]   = r.lo;
          set_hi[free_slot]   = r.hi;
          set_used[free_slot] = 1'b1;
          a.status = ST_OK;
        end
      end
      REQ_ERASE: begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (set_used[i] && set_lo[i] == r.lo && set_hi[i] == r.hi) begin
            set_used[i] = 1'b0;
            a.status = ST_OK;
            return a;
          end
        end
      end
      default: begin
        // half-open overlap; keep the smallest (lo, hi) pair among the hits
        for (int i = 0; i < CAPACITY; i++) begin
          if (set_used[i] && set_lo[i] < r.hi && r.lo < set_hi[i]) begin
            if (!found || set_lo[i] < a.hit_lo ||
                (set_lo[i] == a.hit_lo && set_hi[i] < a.hit_hi)) begin
              a.hit_lo = set_lo[i];
              a.hit_hi = set_hi[i];
              found = 1'b1;
            end
          end
        end
        if (found) a.status = ST_OK;
      end
    endcase
    return a;
  endfunction

  // idle length before the next transfer: mostly short, a few long, and
  // now and then a burst of back-to-back transfers with no idling at all
  function automatic int unsigned pick_pause(inout int unsigned burst);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if (roll < 5) begin
      burst = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // request driver: presents the head of the backlog, predicts on each transfer
  // ---------------------------------------------------------------------------
  request_t    cur_req;
  bit          src_busy = 1'b0;
  int unsigned src_wait = 0;
  int unsigned src_burst = 0;

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      src_busy = 1'b0;
      src_wait = 0;
    end else begin
      // the transfer completes on this edge: the predictor sees it in order
      if (req_ch.valid && req_ch.ready) begin
        awaited_answers.push_back(interval_set_apply(cur_req));
        src_busy = 1'b0;
        src_wait = pick_pause(src_burst);
      end
      if (!src_busy) begin
        if (src_wait > 0) begin
          src_wait--;
        end else if (request_backlog.size() > 0) begin
          cur_req = request_backlog.pop_front();
          src_busy = 1'b1;
        end
      end
      // valid stays high across back-to-back transfers: one assignment per edge
      req_ch.valid    <= src_busy;
      req_ch.req_type <= cur_req.op;
      req_ch.lo       <= cur_req.lo;
      req_ch.hi       <= cur_req.hi;
    end
  end

  // ---------------------------------------------------------------------------
  // response monitor: random backpressure, compares against the oldest answer
  // ---------------------------------------------------------------------------
  int unsigned sink_wait = 0;
  int unsigned sink_burst = 0;

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      sink_wait = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (awaited_answers.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result status %0d hit [%0d, %0d)", $time,
                   rsp_ch.status, rsp_ch.hit_lo, rsp_ch.hit_hi);
        end else begin
          want = awaited_answers.pop_front();
          if (rsp_ch.status !== want.status || rsp_ch.hit_lo !== want.hit_lo ||
              rsp_ch.hit_hi !== want.hit_hi) begin
            error_count++;
            $display("%0t: expected status %0d hit [%0d, %0d) got status %0d hit [%0d, %0d)",
                     $time, want.status, want.hit_lo, want.hit_hi,
                     rsp_ch.status, rsp_ch.hit_lo, rsp_ch.hit_hi);
          end
        end
        sink_wait = pick_pause(sink_burst);
      end else if (sink_wait > 0) begin
        sink_wait--;
      end else if (!rsp_ch.valid && $urandom_range(0, 15) == 0) begin
        // stall ahead of a result so that ready is low when it shows up
        sink_wait = pick_pause(sink_burst);
      end
      rsp_ch.ready <= (sink_wait == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  function automatic void add_request(logic [1:0] op, logic signed [COORD_W-1:0] lo,
                                      logic signed [COORD_W-1:0] hi);
    request_t r;
    r.op = op;
    r.lo = lo;
    r.hi = hi;
    request_backlog.push_back(r);
  endfunction

  initial begin
    request_t                  stored[$];
    request_t                  r;
    logic signed [COORD_W-1:0] base;
    logic signed [COORD_W-1:0] a;
    logic signed [COORD_W-1:0] b;
    int unsigned               random_count;
    int unsigned               run_len;
    int unsigned               ins_pct;
    int unsigned               del_pct;
    int unsigned               roll;
    int unsigned               pick;
    bit                        wide;

    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_INSERT;
    req_ch.lo       = '0;
    req_ch.hi       = '0;
    rsp_ch.ready    = 1'b0;
    foreach (set_used[i]) set_used[i] = 1'b0;
    random_count = 0;

    // directed: coordinate extremes, touching edges, every opcode and rejection
    add_request(REQ_QUERY,  -1, 1);                   // query of the empty set
    add_request(REQ_INSERT, C_MIN, C_MAX);            // widest possible interval
    add_request(REQ_INSERT, C_MIN, C_MAX);            // duplicate insert
    add_request(REQ_QUERY,  0, 1);
    add_request(REQ_INSERT, C_MAX - 1, C_MAX);
    add_request(REQ_INSERT, C_MIN, C_MIN + 1);
    add_request(REQ_QUERY,  C_MAX - 1, C_MAX);        // smallest lo wins
    add_request(REQ_ERASE,  C_MIN, C_MAX);
    add_request(REQ_ERASE,  C_MIN, C_MAX);            // erase of an absent interval
    add_request(REQ_QUERY,  C_MIN + 1, C_MAX - 1);    // only touching ends: no overlap
    add_request(REQ_QUERY,  C_MIN, C_MAX);
    add_request(REQ_INSERT, 5, 5);                    // empty range
    add_request(REQ_INSERT, C_MAX, C_MIN);            // reversed range
    add_request(REQ_ERASE,  7, -7);
    add_request(REQ_QUERY,  3, 3);
    add_request(REQ_UNUSED, 0, 10);                   // unused opcode, good range
    add_request(REQ_UNUSED, 10, 0);
    add_request(REQ_INSERT, -5, 5);
    add_request(REQ_INSERT, -5, 3);
    add_request(REQ_QUERY,  2, 4);                    // same lo: smaller hi wins
    add_request(REQ_ERASE,  C_MAX - 1, C_MAX);
    add_request(REQ_ERASE,  C_MIN, C_MIN + 1);
    add_request(REQ_ERASE,  -5, 5);
    add_request(REQ_ERASE,  -5, 3);

    // random: runs that fill, drain or churn the set around a base point, so
    // that duplicates, overlaps and the full table are all reached
    while (random_count < RANDOM_ITEMS) begin
      run_len = $urandom_range(40, 80);
      wide = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 2))
        0: begin ins_pct = 75; del_pct = 10; end   // fill toward full
        1: begin ins_pct = 15; del_pct = 65; end   // drain
        default: begin ins_pct = 40; del_pct = 30; end
      endcase
      case ($urandom_range(0, 3))
        0: base = C_MIN;
        1: base = C_MAX - 127;
        2: base = 0;
        default: base = $urandom;
      endcase
      for (int k = 0; k < run_len; k++) begin
        roll = $urandom_range(0, 99);
        if (wide) begin
          a = $urandom;
          b = $urandom;
          r.lo = (a < b) ? a : b;
          r.hi = (a < b) ? b : a;
        end else begin
          r.lo = base + int'($urandom_range(0, 96));
          r.hi = r.lo + int'($urandom_range(1, 32));
        end
        if (roll < 3) begin
          r.op = REQ_UNUSED;
        end else if (roll < 3 + ins_pct) begin
          r.op = REQ_INSERT;
          if (stored.size() > 0 && $urandom_range(0, 6) == 0)
            r = stored[$urandom_range(0, stored.size() - 1)];   // duplicate
          else begin
            stored.push_back(r);
            if (stored.size() > 64) void'(stored.pop_front());
          end
          r.op = REQ_INSERT;
        end else if (roll < 3 + ins_pct + del_pct) begin
          if (stored.size() > 0 && $urandom_range(0, 4) != 0) begin
            pick = $urandom_range(0, stored.size() - 1);
            r = stored[pick];
            stored.delete(pick);
          end
          r.op = REQ_ERASE;
        end else begin
          r.op = REQ_QUERY;
          if (!wide) r.hi = r.lo + int'($urandom_range(1, 64));
        end
        // some broken ranges: empty or reversed
        if ($urandom_range(0, 19) == 0) begin
          a = r.lo;
          r.lo = r.hi;
          r.hi = ($urandom_range(0, 1) == 0) ? a : r.lo;
        end
        request_backlog.push_back(r);
        random_count++;
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // drain: everything sent, every answer back, then a quiet tail
    while (request_backlog.size() != 0 || src_busy || awaited_answers.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0 && awaited_answers.size() == 0)
      $display("interval_set_overlap_query_unit regression: pass");
    else
      $display("interval_set_overlap_query_unit regression: fail");
    $finish;
  end

  // watchdog: several times the slowest legal run of all requests with full idling
  initial begin
    #20_000_000;
    $display("interval_set_overlap_query_unit regression: fail");
    $finish;
  end

endmodule
